>>> design/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg: shared types and constants of the axis rotation displacement block
// Fixed point formats, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ard_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 3'd3;

  localparam int LOAD_W = 17;
  localparam int ANG_W  = 34;    // cordic datapath width, Q.30

  localparam logic [31:0] PI_Q30          = 32'd3373259426;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  // cordic state handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              flip;
    logic signed [ANG_W-1:0] cs;
    logic signed [ANG_W-1:0] sn;
    logic signed [ANG_W-1:0] z;
  } cord_t;

  // atan(2^-i) in Q.30, rounded to nearest
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      default: v = 32'd1;
    endcase
    return v;
  endfunction

endpackage

>>> design/ard_if.sv
// ----------------------------------------------------------------------------
// ard_if: stream interfaces of the axis rotation displacement block
// Point input channel and displacement result channel.
// ----------------------------------------------------------------------------
interface ard_in_if import ard_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [LOAD_W-1:0]     load_step;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, load_step, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, load_step, coord_x, coord_y, coord_z, output ready);
endinterface

interface ard_out_if import ard_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] disp_x;
  logic signed [COORD_BITS-1:0] disp_y;
  logic signed [COORD_BITS-1:0] disp_z;
  logic                         clipped;

  modport source (output valid, disp_x, disp_y, disp_z, clipped, input ready);
  modport sink   (input valid, disp_x, disp_y, disp_z, clipped, output ready);
endinterface

>>> design/ard_cell.sv
// ----------------------------------------------------------------------------
// ard_cell: one CORDIC rotation cell
// Rotates (cos, sin) by +-atan(2^-STEP) and passes the point along.
// ----------------------------------------------------------------------------
module ard_cell import ard_pkg::*; #(
  parameter int STEP       = 0,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cord_t                     cord_in,
  input  logic [3*COORD_BITS-1:0]   pt_in,
  output cord_t                     cord_out,
  output logic [3*COORD_BITS-1:0]   pt_out
);

  localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(STEP));

  cord_t                    cord_r, cord_nxt;
  logic [3*COORD_BITS-1:0]  pt_r;
  logic signed [ANG_W-1:0]  xs, ys;

  // micro rotation toward z = 0
  always_comb begin
    xs       = cord_in.cs >>> STEP;
    ys       = cord_in.sn >>> STEP;
    cord_nxt = cord_in;
    if (!cord_in.z[ANG_W-1]) begin
      cord_nxt.cs = cord_in.cs - ys;
      cord_nxt.sn = cord_in.sn + xs;
      cord_nxt.z  = cord_in.z - ATAN;
    end else begin
      cord_nxt.cs = cord_in.cs + ys;
      cord_nxt.sn = cord_in.sn - xs;
      cord_nxt.z  = cord_in.z + ATAN;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cord_r.vld <= 1'b0;
    end else if (en) begin
      cord_r.vld <= cord_nxt.vld;
    end
    if (en) begin
      cord_r.flip <= cord_nxt.flip;
      cord_r.cs   <= cord_nxt.cs;
      cord_r.sn   <= cord_nxt.sn;
      cord_r.z    <= cord_nxt.z;
      pt_r        <= pt_in;
    end
  end

  assign cord_out = cord_r;
  assign pt_out   = pt_r;

endmodule

>>> design/axis_rotation_displacement.sv
// ----------------------------------------------------------------------------
// axis_rotation_displacement: rotation displacement of a point about an axis
// Pipelined Rodrigues displacement with a CORDIC sine and cosine chain.
// ----------------------------------------------------------------------------
// Takes one point per cycle while not stalled and returns one displacement
// per point, in order. There are two phase stages, one CORDIC cell per
// step, then four product and sum stages ending in the output register. The
// whole pipeline advances whenever the output register is empty or being
// taken, so with out ready held high a transaction enters every cycle.
// Configuration must be written while no transaction is in flight.
module axis_rotation_displacement import ard_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ard_in_if.sink                in_ch,
  ard_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W   = COORD_BITS;
  localparam int KPW = W + 2;     // k*p >> 14
  localparam int CXW = W + 3;
  localparam int BPW = W + 5;     // coef*p >> 28
  localparam int BXW = W + 7;
  localparam int DW  = W + 12;
  // full product widths
  localparam int PKW = W + 16;
  localparam int PCW = W + 33;
  localparam int PSW = ANG_W + CXW;
  localparam int POW = ANG_W + 1 + BXW;
  localparam logic signed [DW-1:0] SAT_HI = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [28:0]   QUARTER = 29'sd134217728;
  localparam logic signed [28:0]   HALF    = 29'sd268435456;

  logic en;

  // configuration registers
  logic signed [15:0] kx_r, ky_r, kz_r, ang_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_r  <= '0;
      ky_r  <= '0;
      kz_r  <= '0;
      ang_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_X: kx_r  <= cfg_data;
        REG_AXIS_Y: ky_r  <= cfg_data;
        REG_AXIS_Z: kz_r  <= cfg_data;
        REG_ANGLE:  ang_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // outer product coefficients, follow the axis registers
  logic signed [32:0] cxy_r, cxz_r, cyz_r, sxx_r, syy_r, szz_r;
  always_ff @(posedge clk) begin
    cxy_r <= 33'(kx_r * ky_r);
    cxz_r <= 33'(kx_r * kz_r);
    cyz_r <= 33'(ky_r * kz_r);
    sxx_r <= 33'(ky_r * ky_r) + 33'(kz_r * kz_r);
    syy_r <= 33'(kx_r * kx_r) + 33'(kz_r * kz_r);
    szz_r <= 33'(kx_r * kx_r) + 33'(ky_r * ky_r);
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // phase: angle times load, wrapped to one turn and folded to +-quarter
  logic signed [33:0] ph_prod;
  logic signed [28:0] ph_wrap, ph_fold;
  logic               ph_flip;
  always_comb begin
    ph_prod = 34'(ang_r * $signed({1'b0, in_ch.load_step}));
    ph_wrap = ph_prod[28:0];
    ph_fold = ph_wrap;
    ph_flip = 1'b0;
    if (ph_wrap > QUARTER) begin
      ph_fold = ph_wrap - HALF;
      ph_flip = 1'b1;
    end else if (ph_wrap < -QUARTER) begin
      ph_fold = ph_wrap + HALF;
      ph_flip = 1'b1;
    end
  end

  logic               f0_vld_r, f0_flip_r;
  logic signed [28:0] f0_ph_r;
  logic [3*W-1:0]     f0_pt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (en) begin
      f0_vld_r <= in_ch.valid;
    end
    if (en) begin
      f0_flip_r <= ph_flip;
      f0_ph_r   <= ph_fold;
      f0_pt_r   <= {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
    end
  end

  // phase to radians, Q.30
  logic signed [62:0] rad_prod;
  assign rad_prod = 63'(f0_ph_r * $signed({1'b0, PI_Q30}));

  cord_t          cord [CORDIC_STEPS+1];
  logic [3*W-1:0] pt   [CORDIC_STEPS+1];
  cord_t          f1_r;
  logic [3*W-1:0] f1_pt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld <= 1'b0;
    end else if (en) begin
      f1_r.vld <= f0_vld_r;
    end
    if (en) begin
      f1_r.flip <= f0_flip_r;
      f1_r.cs   <= ANG_W'(CORDIC_GAIN_Q30);
      f1_r.sn   <= '0;
      f1_r.z    <= ANG_W'(rad_prod >>> 28);
      f1_pt_r   <= f0_pt_r;
    end
  end

  assign cord[0] = f1_r;
  assign pt[0]   = f1_pt_r;

  // cordic chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ard_cell #(.STEP(i), .COORD_BITS(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cord_in  (cord[i]),
      .pt_in    (pt[i]),
      .cord_out (cord[i+1]),
      .pt_out   (pt[i+1])
    );
  end

  cord_t                  ce;
  logic signed [W-1:0]    px, py, pz;
  assign ce = cord[CORDIC_STEPS];
  assign px = pt[CORDIC_STEPS][3*W-1:2*W];
  assign py = pt[CORDIC_STEPS][2*W-1:W];
  assign pz = pt[CORDIC_STEPS][W-1:0];

  // products of axis terms and point
  logic                      p1_vld_r;
  logic signed [ANG_W-1:0]   p1_sn_r;
  logic signed [ANG_W:0]     p1_omc_r;
  logic signed [KPW-1:0]     kypz_r, kzpy_r, kzpx_r, kxpz_r, kxpy_r, kypx_r;
  logic signed [BPW-1:0]     bxy_r, bxz_r, bxx_r, byx_r, byz_r, byy_r, bzx_r, bzy_r, bzz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= ce.vld;
    end
    if (en) begin
      p1_sn_r  <= ce.flip ? -ce.sn : ce.sn;
      p1_omc_r <= (ANG_W+1)'(35'sd1073741824)
                  - (ce.flip ? -(ANG_W+1)'(ce.cs) : (ANG_W+1)'(ce.cs));
      kypz_r <= KPW'((PKW'(ky_r) * PKW'(pz)) >>> 14);
      kzpy_r <= KPW'((PKW'(kz_r) * PKW'(py)) >>> 14);
      kzpx_r <= KPW'((PKW'(kz_r) * PKW'(px)) >>> 14);
      kxpz_r <= KPW'((PKW'(kx_r) * PKW'(pz)) >>> 14);
      kxpy_r <= KPW'((PKW'(kx_r) * PKW'(py)) >>> 14);
      kypx_r <= KPW'((PKW'(ky_r) * PKW'(px)) >>> 14);
      bxy_r  <= BPW'((PCW'(cxy_r) * PCW'(py)) >>> 28);
      bxz_r  <= BPW'((PCW'(cxz_r) * PCW'(pz)) >>> 28);
      bxx_r  <= BPW'((PCW'(sxx_r) * PCW'(px)) >>> 28);
      byx_r  <= BPW'((PCW'(cxy_r) * PCW'(px)) >>> 28);
      byz_r  <= BPW'((PCW'(cyz_r) * PCW'(pz)) >>> 28);
      byy_r  <= BPW'((PCW'(syy_r) * PCW'(py)) >>> 28);
      bzx_r  <= BPW'((PCW'(cxz_r) * PCW'(px)) >>> 28);
      bzy_r  <= BPW'((PCW'(cyz_r) * PCW'(py)) >>> 28);
      bzz_r  <= BPW'((PCW'(szz_r) * PCW'(pz)) >>> 28);
    end
  end

  // cross product and outer product sums
  logic                    p2_vld_r;
  logic signed [ANG_W-1:0] p2_sn_r;
  logic signed [ANG_W:0]   p2_omc_r;
  logic signed [CXW-1:0]   cx_r, cy_r, cz_r;
  logic signed [BXW-1:0]   bx_r, by_r, bz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
    if (en) begin
      p2_sn_r  <= p1_sn_r;
      p2_omc_r <= p1_omc_r;
      cx_r <= CXW'(kypz_r) - CXW'(kzpy_r);
      cy_r <= CXW'(kzpx_r) - CXW'(kxpz_r);
      cz_r <= CXW'(kxpy_r) - CXW'(kypx_r);
      bx_r <= BXW'(bxy_r) + BXW'(bxz_r) - BXW'(bxx_r);
      by_r <= BXW'(byx_r) + BXW'(byz_r) - BXW'(byy_r);
      bz_r <= BXW'(bzx_r) + BXW'(bzy_r) - BXW'(bzz_r);
    end
  end

  // trigonometric weighting
  logic                 p3_vld_r;
  logic signed [DW-1:0] sx_r, sy_r, sz_r, ox_r, oy_r, oz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
    if (en) begin
      sx_r <= DW'((PSW'(p2_sn_r) * PSW'(cx_r)) >>> 30);
      sy_r <= DW'((PSW'(p2_sn_r) * PSW'(cy_r)) >>> 30);
      sz_r <= DW'((PSW'(p2_sn_r) * PSW'(cz_r)) >>> 30);
      ox_r <= DW'((POW'(p2_omc_r) * POW'(bx_r)) >>> 30);
      oy_r <= DW'((POW'(p2_omc_r) * POW'(by_r)) >>> 30);
      oz_r <= DW'((POW'(p2_omc_r) * POW'(bz_r)) >>> 30);
    end
  end

  // final sum and saturation
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [W-1:0]  qx, qy, qz;
  logic                 clip;
  always_comb begin
    dx   = sx_r + ox_r;
    dy   = sy_r + oy_r;
    dz   = sz_r + oz_r;
    clip = 1'b0;
    qx   = W'(dx);
    qy   = W'(dy);
    qz   = W'(dz);
    if (dx > SAT_HI) begin qx = W'(SAT_HI); clip = 1'b1; end
    else if (dx < SAT_LO) begin qx = W'(SAT_LO); clip = 1'b1; end
    if (dy > SAT_HI) begin qy = W'(SAT_HI); clip = 1'b1; end
    else if (dy < SAT_LO) begin qy = W'(SAT_LO); clip = 1'b1; end
    if (dz > SAT_HI) begin qz = W'(SAT_HI); clip = 1'b1; end
    else if (dz < SAT_LO) begin qz = W'(SAT_LO); clip = 1'b1; end
  end

  // output register
  logic                out_vld_r, clip_r;
  logic signed [W-1:0] ox_q_r, oy_q_r, oz_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p3_vld_r;
    end
    if (en) begin
      ox_q_r <= qx;
      oy_q_r <= qy;
      oz_q_r <= qz;
      clip_r <= clip;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.disp_x  = ox_q_r;
  assign out_ch.disp_y  = oy_q_r;
  assign out_ch.disp_z  = oz_q_r;
  assign out_ch.clipped = clip_r;

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // a saturated transaction has a component on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |->
      (out_ch.disp_x == W'(SAT_HI)) || (out_ch.disp_x == W'(SAT_LO)) ||
      (out_ch.disp_y == W'(SAT_HI)) || (out_ch.disp_y == W'(SAT_LO)) ||
      (out_ch.disp_z == W'(SAT_HI)) || (out_ch.disp_z == W'(SAT_LO)))
    else $error("clipped without a saturated component");

  // pipeline ready follows the output register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

endmodule

>>> bench/tb_axis_rotation_displacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_rotation_displacement: self-checking bench of the rotation block
// Streams points under a range of axis and angle settings, predicts every
// displacement with a bit-accurate fixed point CORDIC model, and compares
// each result transaction in order with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_axis_rotation_displacement;
  import ard_pkg::*;

  localparam int STEPS   = CORDIC_STEPS_DEF;
  localparam int CBITS   = COORD_BITS_DEF;
  localparam int LATENCY = STEPS + 6;

  typedef struct {
    logic        [LOAD_W-1:0] load;
    logic signed [CBITS-1:0]  x;
    logic signed [CBITS-1:0]  y;
    logic signed [CBITS-1:0]  z;
  } point_t;

  typedef struct {
    logic signed [CBITS-1:0] dx;
    logic signed [CBITS-1:0] dy;
    logic signed [CBITS-1:0] dz;
    logic                    clip;
  } disp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ard_in_if  #(.COORD_BITS(CBITS)) in_ch ();
  ard_out_if #(.COORD_BITS(CBITS)) out_ch ();

  axis_rotation_displacement #(.CORDIC_STEPS(STEPS), .COORD_BITS(CBITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  point_t pending_pts[$];
  disp_t  expected_disp[$];
  int     errors = 0;
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;
  logic   in_taken = 1'b0;
  longint atan_tab[64];

  // shadow copy of the configuration
  logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0, angle_ht = 0;

  localparam longint PI_FX   = 64'd3373259426;
  localparam longint GAIN_FX = 64'd652032874;

  // floor(a * b / 2^s) with a wide intermediate
  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> s;
    return longint'(p[63:0]);
  endfunction

  // atan(2^-i) in Q.30 from the odd power series
  function automatic longint arctan_fx(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = 0;
    if (i == 0) return (PI_FX + 2) >>> 2;
    for (int n = 0; n < 64; n++) begin
      e = 62 - i * (2 * n + 1);
      if (e < 0) break;
      term = (64'd1 << e) / (2 * n + 1);
      if (n % 2) acc = acc - term;
      else acc = acc + term;
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint clamp_coord(longint v, ref logic clip);
    longint hi, lo;
    hi = (longint'(1) <<< (CBITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin clip = 1'b1; return hi; end
    if (v < lo) begin clip = 1'b1; return lo; end
    return v;
  endfunction

  // expected displacement of one point under the current setting
  function automatic disp_t rotate_disp(point_t p);
    disp_t d;
    longint kx, ky, kz, px, py, pz, r, z, cs, sn, xs, ys, omc;
    longint cx, cy, cz, bx, by, bz;
    logic flip, clip;
    kx = axis_x; ky = axis_y; kz = axis_z;
    px = p.x; py = p.y; pz = p.z;
    flip = 1'b0; clip = 1'b0;
    // phase wrap and fold into a half turn
    r = (longint'(angle_ht) * longint'({1'b0, p.load})) & 64'h1FFF_FFFF;
    if (r >= (64'sd1 <<< 28)) r = r - (64'sd1 <<< 29);
    if (r > (64'sd1 <<< 27)) begin r = r - (64'sd1 <<< 28); flip = 1'b1; end
    else if (r < -(64'sd1 <<< 27)) begin r = r + (64'sd1 <<< 28); flip = 1'b1; end
    z = mul_floor(r, PI_FX, 28);
    cs = GAIN_FX; sn = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = cs >>> i; ys = sn >>> i;
      if (z >= 0) begin cs = cs - ys; sn = sn + xs; z = z - atan_tab[i]; end
      else begin cs = cs + ys; sn = sn - xs; z = z + atan_tab[i]; end
    end
    if (flip) begin cs = -cs; sn = -sn; end
    omc = (64'sd1 <<< 30) - cs;
    // cross product and outer-product terms
    cx = mul_floor(ky, pz, 14) - mul_floor(kz, py, 14);
    cy = mul_floor(kz, px, 14) - mul_floor(kx, pz, 14);
    cz = mul_floor(kx, py, 14) - mul_floor(ky, px, 14);
    bx = mul_floor(kx * ky, py, 28) + mul_floor(kx * kz, pz, 28)
       - mul_floor(ky * ky + kz * kz, px, 28);
    by = mul_floor(kx * ky, px, 28) + mul_floor(ky * kz, pz, 28)
       - mul_floor(kx * kx + kz * kz, py, 28);
    bz = mul_floor(kx * kz, px, 28) + mul_floor(ky * kz, py, 28)
       - mul_floor(kx * kx + ky * ky, pz, 28);
    d.dx = clamp_coord(mul_floor(sn, cx, 30) + mul_floor(omc, bx, 30), clip);
    d.dy = clamp_coord(mul_floor(sn, cy, 30) + mul_floor(omc, by, 30), clip);
    d.dz = clamp_coord(mul_floor(sn, cz, 30) + mul_floor(omc, bz, 30), clip);
    d.clip = clip;
    return d;
  endfunction

  // accept side prediction and result checking
  always @(posedge clk) begin
    disp_t e;
    point_t p;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.load = in_ch.load_step; p.x = in_ch.coord_x;
      p.y = in_ch.coord_y; p.z = in_ch.coord_z;
      expected_disp.push_back(rotate_disp(p));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_disp.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
      end else begin
        e = expected_disp.pop_front();
        if (out_ch.disp_x !== e.dx) begin
          $error("disp_x expected %0d actual %0d", e.dx, out_ch.disp_x); errors++;
        end
        if (out_ch.disp_y !== e.dy) begin
          $error("disp_y expected %0d actual %0d", e.dy, out_ch.disp_y); errors++;
        end
        if (out_ch.disp_z !== e.dz) begin
          $error("disp_z expected %0d actual %0d", e.dz, out_ch.disp_z); errors++;
        end
        if (out_ch.clipped !== e.clip) begin
          $error("clipped expected %0d actual %0d", e.clip, out_ch.clipped); errors++;
        end
      end
    end
  end

  // point driver: holds a transaction until it is taken
  always @(negedge clk) begin
    point_t p;
    if (in_taken) void'(pending_pts.pop_front());
    if (!(in_ch.valid && !in_taken)) begin
      if (rst_n && pending_pts.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        p = pending_pts[0];
        in_ch.valid <= 1'b1;
        in_ch.load_step <= p.load;
        in_ch.coord_x <= p.x; in_ch.coord_y <= p.y; in_ch.coord_z <= p.z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.load_step = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_AXIS_X: axis_x = val;
      REG_AXIS_Y: axis_y = val;
      REG_AXIS_Z: axis_z = val;
      REG_ANGLE:  angle_ht = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pts.size() > 0 || in_ch.valid || expected_disp.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_axis(int ax, int ay, int az, int ang);
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(REG_AXIS_X, ax[15:0]);
    write_reg(REG_AXIS_Y, ay[15:0]);
    write_reg(REG_AXIS_Z, az[15:0]);
    write_reg(REG_ANGLE, ang[15:0]);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF - $urandom_range(3);
      1: return 32'sh8000_0000 + $urandom_range(3);
      2, 3: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    case ($urandom_range(9))
      0: p.load = 0;
      1: p.load = 17'd65536;
      2: p.load = $urandom_range(0, 131071);
      default: p.load = $urandom_range(0, 65536);
    endcase
    p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
    return p;
  endfunction

  function automatic point_t mk_point(int load, int x, int y, int z);
    point_t p;
    p.load = load; p.x = x; p.y = y; p.z = z;
    return p;
  endfunction

  function automatic int rand_reg();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // stimulus sequencing
  initial begin
    for (int i = 0; i < 64; i++) atan_tab[i] = arctan_fx(i);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: unit x axis, one half turn
    set_axis(16384, 0, 0, 4096);
    pending_pts.push_back(mk_point(0, 32'h0001_0000, 32'h0001_0000, 0));
    pending_pts.push_back(mk_point(65536, 0, 32'h0001_0000, 0));
    pending_pts.push_back(mk_point(32768, 0, 32'h0001_0000, 32'h0002_0000));
    pending_pts.push_back(mk_point(131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pts.push_back(mk_point(98304, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_pts.push_back(mk_point(16384, -1, 32'h7FFF_FFFF, 32'h8000_0000));
    // large angle wraps, extreme axis clips
    set_axis(32767, -32768, 32767, 32767);
    pending_pts.push_back(mk_point(65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_pts.push_back(mk_point(131071, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_pts.push_back(mk_point(12345, 32'h0100_0000, -32'sh0100_0000, 5));
    pending_pts.push_back(mk_point(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    set_axis(-32768, -32768, -32768, -32768);
    pending_pts.push_back(mk_point(65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
    pending_pts.push_back(mk_point(43690, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // zero axis gives zero displacement
    set_axis(0, 0, 0, 12000);
    pending_pts.push_back(mk_point(65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
    pending_pts.push_back(mk_point(131071, -5, 7, 9));

    // random phases cycling the idling modes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) set_axis(0, 0, 16384, $signed($urandom_range(0, 65535)) - 32768);
      else set_axis(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 18; snk_stall_pct = 18; end
      endcase
      for (int n = 0; n < 140; n++) pending_pts.push_back(rand_point());
      // sender holds off until the pipeline is empty
      if (ph == 5) drain();
      for (int n = 0; n < 1; n++) pending_pts.push_back(rand_point());
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
